// ----- src/hms_pkg.sv -----
package hms_pkg;

  // store geometry
  localparam int CTRL_DIM    = 64;
  localparam int MESH_MAX    = 256;
  localparam int CTRL_BITS   = $clog2(CTRL_DIM);
  localparam int ADDR_BITS   = 2 * CTRL_BITS;
  localparam int STORE_DEPTH = CTRL_DIM * CTRL_DIM;

  // field widths
  localparam int IDX_W  = 9;
  localparam int GRID_W = 9;
  localparam int HALF_W = GRID_W - 1;
  localparam int SPAN_W = 7;
  localparam int SQ_W   = 2 * SPAN_W;
  localparam int STEP_W = 16;
  localparam int POS_W  = 24;
  localparam int HGT_W  = 16;
  localparam int PROD_W = IDX_W + 1 + STEP_W + 1;
  localparam int ACC_W  = HGT_W + SPAN_W;
  localparam int TOT_W  = HGT_W + SQ_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP = 2'd2;
  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 9'd256;
  localparam logic [SPAN_W-1:0] CELL_SPAN_RST = 7'd15;
  localparam logic [STEP_W-1:0] GRID_STEP_RST = 16'd256;

  // item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // position clamp
  localparam logic signed [PROD_W-1:0] POS_LIMIT     = 27'sd8388480;
  localparam logic signed [PROD_W-1:0] POS_LIMIT_NEG = -27'sd8388480;

  // height sign bias
  localparam logic [HGT_W-1:0] HGT_BIAS = 16'h8000;

  // iterative dividers
  localparam int FRONT_DIV_STEPS  = 3;
  localparam int FRONT_DIV_CYCLES = IDX_W / FRONT_DIV_STEPS;
  localparam int BACK_DIV_STEPS   = 4;
  localparam int BACK_DIV_CYCLES  = HGT_W / BACK_DIV_STEPS;

  // job queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // classified work handed from front to back
  typedef struct packed {
    logic                 load;
    logic                 oor;
    logic [CTRL_BITS-1:0] r;
    logic [CTRL_BITS-1:0] c;
    logic [SPAN_W-1:0]    fr;
    logic [SPAN_W-1:0]    fc;
    logic [SPAN_W-1:0]    span;
    logic [SQ_W-1:0]      sq;
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     z;
    logic [HGT_W-1:0]     h;
  } job_t;

endpackage

// ----- src/hms_if.sv -----
interface hms_in_if;
  import hms_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [HGT_W-1:0]  load_height;

  modport source (output valid, cmd, row_index, col_index, load_height, input ready);
  modport sink   (input valid, cmd, row_index, col_index, load_height, output ready);
endinterface

interface hms_out_if;
  import hms_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  x_pos;
  logic signed [POS_W-1:0]  z_pos;
  logic signed [HGT_W-1:0]  height;
  logic                     out_of_range;

  modport source (output valid, x_pos, z_pos, height, out_of_range, input ready);
  modport sink   (input valid, x_pos, z_pos, height, out_of_range, output ready);
endinterface

// ----- src/hms_front.sv -----
module hms_front (
  input  logic                            clk,
  input  logic                            rst,
  hms_in_if.sink                          item_in,
  input  logic                            cfg_we,
  input  logic [hms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hms_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output hms_pkg::job_t                   push_job
);
  import hms_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]              state;
  logic [1:0]              cnt;
  logic [GRID_W-1:0]       grid_size;
  logic [SPAN_W-1:0]       cell_span;
  logic [STEP_W-1:0]       grid_step;

  logic                    item_load;
  logic [IDX_W-1:0]        item_row;
  logic [IDX_W-1:0]        item_col;
  logic [HGT_W-1:0]        item_hgt;
  logic [SPAN_W-1:0]       span;
  logic [SQ_W-1:0]         sq;
  logic [HALF_W-1:0]       half;
  logic [SPAN_W-1:0]       row_rem;
  logic [SPAN_W-1:0]       col_rem;
  logic [IDX_W-1:0]        row_quo;
  logic [IDX_W-1:0]        col_quo;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_z;

  logic                    accept;
  logic                    in_store;
  logic signed [IDX_W:0]   dx;
  logic signed [IDX_W:0]   dz;
  logic                    oor;

  // a few restoring steps of index / span
  function automatic logic [SPAN_W+IDX_W-1:0] div_front(
    input logic [SPAN_W+IDX_W-1:0] w,
    input logic [SPAN_W-1:0]       d
  );
    logic [SPAN_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
    logic [SPAN_W:0]   t;
    rem = w[SPAN_W+IDX_W-1:IDX_W];
    quo = w[IDX_W-1:0];
    for (int k = 0; k < FRONT_DIV_STEPS; k++) begin
      t = {rem, quo[IDX_W-1]};
      if (t >= {1'b0, d}) begin
        rem = SPAN_W'(t - {1'b0, d});
        quo = {quo[IDX_W-2:0], 1'b1};
      end else begin
        rem = t[SPAN_W-1:0];
        quo = {quo[IDX_W-2:0], 1'b0};
      end
    end
    return {rem, quo};
  endfunction

  // clamp a position product into the output range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] p);
    if (p > POS_LIMIT) begin
      return POS_LIMIT[POS_W-1:0];
    end else if (p < POS_LIMIT_NEG) begin
      return POS_LIMIT_NEG[POS_W-1:0];
    end
    return p[POS_W-1:0];
  endfunction

  assign item_in.ready = (state == F_IDLE);
  assign accept        = item_in.valid && item_in.ready;
  assign in_store      = (32'(item_in.row_index) < CTRL_DIM) &&
                         (32'(item_in.col_index) < CTRL_DIM);

  // signed offsets from the grid center
  assign dx = $signed({1'b0, item_row}) - $signed({2'b00, half});
  assign dz = $signed({1'b0, item_col}) - $signed({2'b00, half});

  // cell beyond the store or index past the mesh
  assign oor = (32'(item_row) > MESH_MAX) || (32'(item_col) > MESH_MAX) ||
               (32'(row_quo) + 32'd1 >= CTRL_DIM) || (32'(col_quo) + 32'd1 >= CTRL_DIM);

  // front control and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      cnt       <= '0;
      grid_size <= GRID_SIZE_RST;
      cell_span <= CELL_SPAN_RST;
      grid_step <= GRID_STEP_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_SIZE: grid_size <= cfg_data[GRID_W-1:0];
          CFG_CELL_SPAN: cell_span <= cfg_data[SPAN_W-1:0];
          CFG_GRID_STEP: grid_step <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            item_load <= (item_in.cmd == CMD_LOAD);
            item_row  <= item_in.row_index;
            item_col  <= item_in.col_index;
            item_hgt  <= item_in.load_height;
            span      <= (cell_span == '0) ? SPAN_W'(1) : cell_span;
            half      <= grid_size[GRID_W-1:1];
            row_rem   <= '0;
            col_rem   <= '0;
            row_quo   <= item_in.row_index;
            col_quo   <= item_in.col_index;
            cnt       <= '0;
            if (item_in.cmd == CMD_LOAD) begin
              if (in_store) begin
                state <= F_PUSH;
              end
            end else begin
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          {row_rem, row_quo} <= div_front({row_rem, row_quo}, span);
          {col_rem, col_quo} <= div_front({col_rem, col_quo}, span);
          prod_x <= dx * $signed({1'b0, grid_step});
          prod_z <= dz * $signed({1'b0, grid_step});
          sq     <= SQ_W'(span) * SQ_W'(span);
          cnt    <= cnt + 2'd1;
          if (cnt == 2'(FRONT_DIV_CYCLES - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // classified job toward the queue
  always_comb begin
    push_job.load = item_load;
    push_job.oor  = !item_load && oor;
    push_job.r    = item_load ? item_row[CTRL_BITS-1:0] : row_quo[CTRL_BITS-1:0];
    push_job.c    = item_load ? item_col[CTRL_BITS-1:0] : col_quo[CTRL_BITS-1:0];
    push_job.fr   = row_rem;
    push_job.fc   = col_rem;
    push_job.span = span;
    push_job.sq   = sq;
    push_job.x    = sat_pos(prod_x);
    push_job.z    = sat_pos(prod_z);
    push_job.h    = item_hgt;
  end

  assign push_valid = (state == F_PUSH);

endmodule

// ----- src/hms_queue.sv -----
module hms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hms_pkg::job_t  push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hms_pkg::job_t  pop_job
);
  import hms_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- src/hms_back.sv -----
module hms_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  hms_pkg::job_t  pop_job,
  hms_out_if.source      result_out
);
  import hms_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD   = 3'd1;
  localparam logic [2:0] B_MIX  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]            state;
  logic [2:0]            rd_cnt;
  logic [1:0]            div_cnt;
  job_t                  cur;

  logic [HGT_W-1:0]      store_mem [STORE_DEPTH];
  logic [HGT_W-1:0]      rdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_BITS-1:0]  waddr;
  logic [ADDR_BITS-1:0]  raddr;

  logic [ACC_W-1:0]      acc0;
  logic [ACC_W-1:0]      acc1;
  logic [1:0]            ent;
  logic [HGT_W-1:0]      biased;
  logic [SPAN_W-1:0]     weight;
  logic [ACC_W-1:0]      prod;
  logic [TOT_W-1:0]      tot;
  logic [SQ_W-1:0]       rem;
  logic [HGT_W-1:0]      quo;

  logic                  out_valid;
  logic [POS_W-1:0]      out_x;
  logic [POS_W-1:0]      out_z;
  logic [HGT_W-1:0]      out_height;
  logic                  out_oor;
  logic                  out_free;
  logic                  take;

  // a few restoring steps of total / span squared
  function automatic logic [SQ_W+HGT_W-1:0] div_back(
    input logic [SQ_W+HGT_W-1:0] w,
    input logic [SQ_W-1:0]       d
  );
    logic [SQ_W-1:0]  r;
    logic [HGT_W-1:0] q;
    logic [SQ_W:0]    t;
    r = w[SQ_W+HGT_W-1:HGT_W];
    q = w[HGT_W-1:0];
    for (int k = 0; k < BACK_DIV_STEPS; k++) begin
      t = {r, q[HGT_W-1]};
      if (t >= {1'b0, d}) begin
        r = SQ_W'(t - {1'b0, d});
        q = {q[HGT_W-2:0], 1'b1};
      end else begin
        r = t[SQ_W-1:0];
        q = {q[HGT_W-2:0], 1'b0};
      end
    end
    return {r, q};
  endfunction

  assign pop_ready = (state == B_IDLE);
  assign take      = pop_valid && pop_ready;
  assign out_free  = !out_valid || result_out.ready;

  // store ports: loads write, samples read four corners
  assign mem_we = take && pop_job.load;
  assign waddr  = {pop_job.r, pop_job.c};
  assign mem_re = (state == B_RD) && (rd_cnt < 3'd4);
  assign raddr  = {CTRL_BITS'(cur.r + CTRL_BITS'(rd_cnt[1])),
                   CTRL_BITS'(cur.c + CTRL_BITS'(rd_cnt[0]))};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[waddr] <= pop_job.h;
    end
    if (mem_re) begin
      rdata <= store_mem[raddr];
    end
  end

  // corner weighting along the column
  assign ent    = 2'(rd_cnt - 3'd1);
  assign biased = rdata ^ HGT_BIAS;
  assign weight = ent[0] ? cur.fc : SPAN_W'(cur.span - cur.fc);
  assign prod   = ACC_W'(biased) * ACC_W'(weight);

  // blend along the row
  assign tot = TOT_W'(acc0) * TOT_W'(SPAN_W'(cur.span - cur.fr)) +
               TOT_W'(acc1) * TOT_W'(cur.fr);

  // back sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rd_cnt    <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: load a finished result, drop it once taken
      if (state == B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (take) begin
            cur    <= pop_job;
            rd_cnt <= '0;
            if (pop_job.oor) begin
              state <= B_OUT;
            end else if (!pop_job.load) begin
              state <= B_RD;
            end
          end
        end
        B_RD: begin
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt != 3'd0) begin
            if (ent[1]) begin
              acc1 <= ent[0] ? ACC_W'(acc1 + prod) : prod;
            end else begin
              acc0 <= ent[0] ? ACC_W'(acc0 + prod) : prod;
            end
          end
          if (rd_cnt == 3'd4) begin
            state <= B_MIX;
          end
        end
        B_MIX: begin
          rem     <= tot[TOT_W-1:HGT_W];
          quo     <= tot[HGT_W-1:0];
          div_cnt <= '0;
          state   <= B_DIV;
        end
        B_DIV: begin
          {rem, quo} <= div_back({rem, quo}, cur.sq);
          div_cnt    <= div_cnt + 2'd1;
          if (div_cnt == 2'(BACK_DIV_CYCLES - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_x      <= cur.x;
            out_z      <= cur.z;
            out_height <= cur.oor ? '0 : (quo ^ HGT_BIAS);
            out_oor    <= cur.oor;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.x_pos        = $signed(out_x);
  assign result_out.z_pos        = $signed(out_z);
  assign result_out.height       = $signed(out_height);
  assign result_out.out_of_range = out_oor;

  // divider leaves a proper remainder
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV && div_cnt == 2'(BACK_DIV_CYCLES - 1)) |=> (rem < cur.sq))
    else $error("remainder not below span squared after divide");

  // only in-range samples reach the corner reads, and the next row and column exist
  a_rd_job: assert property (@(posedge clk) disable iff (rst)
    (state == B_RD) |-> (!cur.load && !cur.oor && cur.r != CTRL_BITS'(CTRL_DIM - 1) &&
                         cur.c != CTRL_BITS'(CTRL_DIM - 1)))
    else $error("corner read for a job outside the store");

  // out-of-range results carry zero height
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_oor) |-> (out_height == '0))
    else $error("out-of-range result with nonzero height");

  // a finished sample waits while the output register is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_valid && !result_out.ready) |=> (state == B_OUT))
    else $error("sample left the output step while the result was stalled");

endmodule

// ----- src/bilinear_heightmap_sampler.sv -----
// Bilinear heightmap sampler.
// item_in takes load items (cmd 0: control row, column and height) and sample
// items (cmd 1: mesh row and column). result_out gives one result per sample:
// centered x and z positions in Q15.8 and the bilinear height in Q7.8, with
// out_of_range set and height zero when the cell lies beyond the control store
// or the index past the mesh. Loads give no result; a load outside the store
// is dropped. Registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while idle; the block itself does not enforce it.
// The front takes one item, splits a sample's row and column by the cell span
// and queues a job, and takes no new item until that job is queued.
// The back takes a queued job whenever it is idle; an in-range sample there
// makes four reads of the control store, blends them and divides by span
// squared before its result is registered.
// A 4-entry job queue separates front and back, so items keep being accepted
// while the receiver stalls until the queue fills; the result then holds in
// the output register. Reset clears control state and loads default register
// values; the store contents stay undefined until written.
module bilinear_heightmap_sampler (
  input  logic                            clk,
  input  logic                            rst,
  hms_in_if.sink                          item_in,
  hms_out_if.source                       result_out,
  input  logic                            cfg_we,
  input  logic [hms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hms_pkg::*;

  logic  push_valid;
  logic  push_ready;
  job_t  push_job;
  logic  pop_valid;
  logic  pop_ready;
  job_t  pop_job;

  // item classification and index split
  hms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // job queue between front and back
  hms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // store access, interpolation and result
  hms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .result_out (result_out)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hms_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 20_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SHOWN_ERRORS  = 40;
  localparam int unsigned IDX_TOP       = (1 << IDX_W) - 1;

  // expected result of one sample item
  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] z_pos;
    logic signed [HGT_W-1:0] height;
    logic                    out_of_range;
  } vertex_t;

  class heightmap_scoreboard;
    logic [HGT_W-1:0]  ctrl_heights [STORE_DEPTH];
    logic [GRID_W-1:0] grid_size;
    logic [SPAN_W-1:0] cell_span;
    logic [STEP_W-1:0] grid_step;
    vertex_t           pending_vertices [$];
    int unsigned       mismatches;

    function new();
      foreach (ctrl_heights[i]) ctrl_heights[i] = '0;
      grid_size  = GRID_SIZE_RST;
      cell_span  = CELL_SPAN_RST;
      grid_step  = GRID_STEP_RST;
      mismatches = 0;
    endfunction

    task report(input string msg);
      if (mismatches < SHOWN_ERRORS) $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    // (idx - half) * step, clamped to the position range
    function logic [POS_W-1:0] centered_pos(input logic [IDX_W-1:0] idx);
      longint base, half, step, v;
      base = idx;
      half = grid_size >> 1;
      step = grid_step;
      v = (base - half) * step;
      if (v > POS_LIMIT) v = POS_LIMIT;
      if (v < POS_LIMIT_NEG) v = POS_LIMIT_NEG;
      return v[POS_W-1:0];
    endfunction

    // stored height moved to 0..65535
    function longint unsigned biased_height(input int unsigned r, input int unsigned c);
      longint unsigned b;
      b = ctrl_heights[r * CTRL_DIM + c] ^ HGT_BIAS;
      return b;
    endfunction

    function vertex_t predict_vertex(input logic [IDX_W-1:0] row, col);
      vertex_t v;
      int unsigned span, cr, cc, fr, fc;
      longint unsigned s, a0, a1, tot, q;
      span = (cell_span == 0) ? 1 : cell_span;
      cr = row / span;
      fr = row % span;
      cc = col / span;
      fc = col % span;
      v.row = row;
      v.col = col;
      v.x_pos = centered_pos(row);
      v.z_pos = centered_pos(col);
      v.out_of_range = (row > MESH_MAX) || (col > MESH_MAX) ||
                       (cr + 1 >= CTRL_DIM) || (cc + 1 >= CTRL_DIM);
      v.height = '0;
      if (!v.out_of_range) begin
        // along the column first, then along the row, exact until the final floor
        s = span;
        a0 = biased_height(cr, cc) * (s - fc) + biased_height(cr, cc + 1) * fc;
        a1 = biased_height(cr + 1, cc) * (s - fc) + biased_height(cr + 1, cc + 1) * fc;
        tot = a0 * (s - fr) + a1 * fr;
        q = tot / (s * s) - HGT_BIAS;
        v.height = q[HGT_W-1:0];
      end
      return v;
    endfunction

    task note_accepted(input logic cmd, input logic [IDX_W-1:0] row, col,
                       input logic [HGT_W-1:0] h);
      if (cmd == CMD_LOAD) begin
        if (row < CTRL_DIM && col < CTRL_DIM) ctrl_heights[row * CTRL_DIM + col] = h;
      end else begin
        pending_vertices.insert(pending_vertices.size(), predict_vertex(row, col));
      end
    endtask

    task check_result(input logic signed [POS_W-1:0] x, z,
                      input logic signed [HGT_W-1:0] h, input logic oor);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        report("result with no sample pending");
        return;
      end
      want = pending_vertices.pop_front();
      if (x !== want.x_pos)
        report($sformatf("vertex (%0d,%0d) x_pos %0d, expected %0d",
                         want.row, want.col, x, want.x_pos));
      if (z !== want.z_pos)
        report($sformatf("vertex (%0d,%0d) z_pos %0d, expected %0d",
                         want.row, want.col, z, want.z_pos));
      if (h !== want.height)
        report($sformatf("vertex (%0d,%0d) height %0d, expected %0d",
                         want.row, want.col, h, want.height));
      if (oor !== want.out_of_range)
        report($sformatf("vertex (%0d,%0d) out_of_range %b, expected %b",
                         want.row, want.col, oor, want.out_of_range));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hms_in_if  item_if ();
  hms_out_if result_if ();

  bilinear_heightmap_sampler i_dut (
    .clk,
    .rst,
    .item_in    (item_if),
    .result_out (result_if),
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  heightmap_scoreboard sb = new();

  bit          written [STORE_DEPTH];
  int unsigned cur_span = CELL_SPAN_RST;
  int unsigned item_count;
  int unsigned cycle_count = 0;
  bit          steady_send = 1'b0;
  bit          steady_take = 1'b0;
  bit          hold_request = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (item_if.valid && item_if.ready)
        sb.note_accepted(item_if.cmd, item_if.row_index, item_if.col_index,
                         item_if.load_height);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.x_pos, result_if.z_pos, result_if.height,
                        result_if.out_of_range);
    end
  end

  // result side: random back-pressure, one long hold when asked
  initial begin
    int unsigned stall_left, roll;
    stall_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else if (steady_take) begin
        result_if.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          result_if.ready <= 1'b1;
        end else begin
          stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
          result_if.ready <= 1'b0;
        end
      end
    end
  end

  // pause between items, mostly none or short
  task automatic idle_gap();
    int unsigned roll, n;
    n = 0;
    if (!steady_send) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) n = $urandom_range(8, 40);
      else if (roll >= 55) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      item_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] row, col,
                           input logic [HGT_W-1:0] h);
    item_if.valid       <= 1'b1;
    item_if.cmd         <= cmd;
    item_if.row_index   <= row;
    item_if.col_index   <= col;
    item_if.load_height <= h;
    do @(posedge clk); while (!item_if.ready);
    idle_gap();
  endtask

  function automatic logic [HGT_W-1:0] random_height();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      default: return HGT_W'($urandom);
    endcase
  endfunction

  task automatic load_ctrl(input int unsigned row, col, input logic [HGT_W-1:0] h);
    send_item(CMD_LOAD, IDX_W'(row), IDX_W'(col), h);
    if (row < CTRL_DIM && col < CTRL_DIM) begin
      written[row * CTRL_DIM + col] = 1'b1;
      item_count++;
    end
  endtask

  // true when a sample of this vertex reads four control heights
  function automatic bit reads_store(input int unsigned row, col);
    return row <= MESH_MAX && col <= MESH_MAX &&
           row / cur_span + 1 < CTRL_DIM && col / cur_span + 1 < CTRL_DIM;
  endfunction

  // fill any corner of the cell that has never been loaded
  task automatic fill_cell(input int unsigned cr, cc);
    for (int dr = 0; dr < 2; dr++)
      for (int dc = 0; dc < 2; dc++)
        if (!written[(cr + dr) * CTRL_DIM + cc + dc])
          load_ctrl(cr + dr, cc + dc, random_height());
  endtask

  task automatic sample_vertex(input int unsigned row, col);
    if (reads_store(row, col)) fill_cell(row / cur_span, col / cur_span);
    send_item(CMD_SAMPLE, IDX_W'(row), IDX_W'(col), HGT_W'($urandom));
    item_count++;
  endtask

  task automatic random_item();
    int unsigned roll, top, cr, cc, lo;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      // fresh cell corners, then a few vertices inside that cell
      top = MESH_MAX / cur_span;
      if (top > CTRL_DIM - 2) top = CTRL_DIM - 2;
      cr = $urandom_range(0, top);
      cc = $urandom_range(0, top);
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          load_ctrl(cr + dr, cc + dc, random_height());
      repeat ($urandom_range(1, 3))
        sample_vertex(cr * cur_span + $urandom_range(0, cur_span - 1),
                      cc * cur_span + $urandom_range(0, cur_span - 1));
    end else if (roll < 65) begin
      top = (CTRL_DIM - 1) * cur_span;
      if (top > MESH_MAX) top = MESH_MAX;
      sample_vertex($urandom_range(0, top), $urandom_range(0, top));
    end else if (roll < 80) begin
      // beyond the mesh, or a cell whose far neighbor is missing from the store
      lo = (CTRL_DIM - 1) * cur_span;
      if (lo > MESH_MAX || $urandom_range(0, 1)) lo = MESH_MAX + 1;
      if ($urandom_range(0, 1))
        sample_vertex($urandom_range(lo, IDX_TOP), $urandom_range(0, IDX_TOP));
      else
        sample_vertex($urandom_range(0, IDX_TOP), $urandom_range(lo, IDX_TOP));
    end else if (roll < 90) begin
      top = $urandom_range(0, 1) ? CTRL_DIM - 1 : IDX_TOP;
      load_ctrl($urandom_range(0, top), $urandom_range(0, top), random_height());
    end else begin
      sample_vertex($urandom_range(0, IDX_TOP), $urandom_range(0, IDX_TOP));
    end
  endtask

  // wait out every pending sample, then let trailing loads settle
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    item_if.valid <= 1'b0;
    while (sb.pending_vertices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_vertices.size() != 0) begin
      sb.report($sformatf("%0d samples never answered", sb.pending_vertices.size()));
      sb.pending_vertices.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [GRID_W-1:0] grid, input logic [SPAN_W-1:0] span,
                            input logic [STEP_W-1:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_SIZE;
    cfg_data  <= CFG_DATA_W'(grid);
    @(posedge clk);
    cfg_index <= CFG_CELL_SPAN;
    cfg_data  <= CFG_DATA_W'(span);
    @(posedge clk);
    cfg_index <= CFG_GRID_STEP;
    cfg_data  <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.grid_size = grid;
    sb.cell_span = span;
    sb.grid_step = step;
    cur_span = (span == 0) ? 1 : span;
  endtask

  task automatic run_phase(input bit write_cfg, input logic [GRID_W-1:0] grid,
                           input logic [SPAN_W-1:0] span, input logic [STEP_W-1:0] step,
                           input bit steady, input bit pressure);
    if (write_cfg) set_config(grid, span, step);
    steady_send  = steady || pressure;
    steady_take  = steady;
    hold_request = pressure;
    item_count = 0;
    while (item_count < RANDOM_ITEMS / NUM_PHASES) random_item();
    drain_results();
    steady_send = 1'b0;
    steady_take = 1'b0;
  endtask

  task automatic directed_items();
    // opposite extremes on the corners of the first cell
    load_ctrl(0, 0, 16'h8000);
    load_ctrl(0, 1, 16'h7FFF);
    load_ctrl(1, 0, 16'h7FFF);
    load_ctrl(1, 1, 16'h8000);
    sample_vertex(0, 0);
    sample_vertex(7, 8);
    sample_vertex(14, 14);
    sample_vertex(1, 14);
    // loads outside the store are dropped and leave the first cell alone
    load_ctrl(CTRL_DIM, 0, '0);
    load_ctrl(0, CTRL_DIM, '0);
    load_ctrl(IDX_TOP, IDX_TOP, 16'h1234);
    sample_vertex(0, 0);
    // last mesh vertex, then past the mesh on each axis
    sample_vertex(MESH_MAX, MESH_MAX);
    sample_vertex(MESH_MAX + 1, 0);
    sample_vertex(0, MESH_MAX + 1);
    sample_vertex(IDX_TOP, IDX_TOP);
  endtask

  initial begin
    item_if.valid       <= 1'b0;
    item_if.cmd         <= CMD_LOAD;
    item_if.row_index   <= '0;
    item_if.col_index   <= '0;
    item_if.load_height <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_GRID_SIZE;
    cfg_data            <= '0;
    rst                 <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    // reset settings, then the register extremes and a few in between
    run_phase(1'b0, GRID_SIZE_RST, CELL_SPAN_RST, GRID_STEP_RST, 1'b0, 1'b0);
    run_phase(1'b1, '0, '0, '0, 1'b0, 1'b0);
    run_phase(1'b1, '1, 7'd64, '1, 1'b1, 1'b0);
    run_phase(1'b1, 9'd1, 7'd1, 16'd1, 1'b0, 1'b0);
    run_phase(1'b1, 9'd256, 7'd7, 16'h8080, 1'b0, 1'b1);
    run_phase(1'b1, 9'd255, '1, 16'hFFFF, 1'b0, 1'b0);
    run_phase(1'b1, GRID_W'($urandom), SPAN_W'($urandom_range(1, 64)), STEP_W'($urandom),
              1'b0, 1'b0);
    run_phase(1'b1, 9'd2, 7'd15, 16'h0100, 1'b1, 1'b0);

    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
